// ----- rtl/rtsp_pkg.sv -----
// shared types and constants for the reachability tlv stream parser
`default_nettype none
package rtsp_pkg;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_TYPE    = 10'b00_0000_0010,
    PH_LEN     = 10'b00_0000_0100,
    PH_NBR     = 10'b00_0000_1000,
    PH_PMET    = 10'b00_0001_0000,
    PH_PCTL    = 10'b00_0010_0000,
    PH_PBYTES  = 10'b00_0100_0000,
    PH_PSUBLEN = 10'b00_1000_0000,
    PH_SUBSKIP = 10'b01_0000_0000,
    PH_TLVSKIP = 10'b10_0000_0000
  } phase_t;

  localparam logic [1:0] KIND_NBR    = 2'd0;
  localparam logic [1:0] KIND_PREFIX = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_HDR_SHORT   = 4'd1;
  localparam logic [3:0] ERR_TLV_OVERRUN = 4'd2;
  localparam logic [3:0] ERR_NBR_SHORT   = 4'd3;
  localparam logic [3:0] ERR_NBR_SUB     = 4'd4;
  localparam logic [3:0] ERR_PFX_SHORT   = 4'd5;
  localparam logic [3:0] ERR_LEN_OVER    = 4'd6;
  localparam logic [3:0] ERR_PFX_BYTES   = 4'd7;
  localparam logic [3:0] ERR_SUBLEN_MISS = 4'd8;
  localparam logic [3:0] ERR_SUB_OVERRUN = 4'd9;

  localparam logic [7:0] TLV_EXT_IS_REACH = 8'd22;
  localparam logic [7:0] TLV_EXT_IP_REACH = 8'd135;
  localparam logic [7:0] NBR_ITEM_BYTES   = 8'd11;
  localparam logic [7:0] PFX_ITEM_MIN     = 8'd5;
  localparam logic [5:0] PFX_LEN_MAX      = 6'd32;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        area_start;
    logic [15:0] area_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [3:0]  error_code;
    logic [55:0] neighbor_id;
    logic [31:0] metric;
    logic        down_bit;
    logic [31:0] prefix_value;
    logic [5:0]  prefix_length;
    logic        host_bits_set;
    logic [7:0]  subtlv_length;
    logic        last_result;
  } res_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  tlv_code;
    logic [7:0]  tlv_left;
    logic [3:0]  field_count;
    logic [55:0] id_shift;
    logic [31:0] metric_shift;
    logic [7:0]  control_hold;
    logic [31:0] prefix_shift;
    logic [7:0]  skip_left;
  } parse_st_t;

endpackage
`default_nettype wire

// ----- rtl/rtsp_parse.sv -----
// per-byte parse state and result decode
`default_nettype none
module rtsp_parse #(
  parameter int LW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire rtsp_pkg::in_item_t item,
  output logic [1:0]             res_cnt,
  output rtsp_pkg::res_item_t    res0,
  output rtsp_pkg::res_item_t    res1
);
  import rtsp_pkg::*;

  parse_st_t     st, st_next;
  logic [LW-1:0] area_left, area_left_next;

  function automatic res_item_t mk(input logic [1:0] k, input logic [3:0] e);
    res_item_t r;
    r = '0;
    r.record_kind = k;
    r.error_code = e;
    return r;
  endfunction

  function automatic void put(inout res_item_t r0, inout res_item_t r1,
                              inout logic [1:0] n, input res_item_t r);
    if (n == 2'd0) r0 = r;
    else if (n == 2'd1) r1 = r;
    if (n != 2'd2) n = n + 2'd1;
  endfunction

  function automatic void fail(inout parse_st_t s, inout res_item_t r0,
                               inout res_item_t r1, inout logic [1:0] n,
                               input logic [3:0] e);
    put(r0, r1, n, mk(KIND_ERROR, e));
    s.phase = PH_IDLE;
  endfunction

  function automatic logic [3:0] pfx_bytes(input logic [7:0] ctl);
    logic [6:0] t;
    t = {1'b0, ctl[5:0]} + 7'd7;
    return t[6:3];
  endfunction

  function automatic void advance(inout parse_st_t s, input logic [LW-1:0] al,
                                  inout res_item_t r0, inout res_item_t r1,
                                  inout logic [1:0] n);
    if (s.tlv_left == 8'd0) begin
      if (al == '0) begin
        put(r0, r1, n, mk(KIND_DONE, ERR_NONE));
        s.phase = PH_IDLE;
      end else if (al < LW'(2)) begin
        fail(s, r0, r1, n, ERR_HDR_SHORT);
      end else begin
        s.phase = PH_TYPE;
      end
    end else if (s.tlv_code == TLV_EXT_IS_REACH) begin
      if (s.tlv_left < NBR_ITEM_BYTES) begin
        fail(s, r0, r1, n, ERR_NBR_SHORT);
      end else begin
        s.phase = PH_NBR;
        s.field_count = '0;
        s.id_shift = '0;
        s.metric_shift = '0;
      end
    end else if (s.tlv_code == TLV_EXT_IP_REACH) begin
      if (s.tlv_left < PFX_ITEM_MIN) begin
        fail(s, r0, r1, n, ERR_PFX_SHORT);
      end else begin
        s.phase = PH_PMET;
        s.field_count = '0;
        s.metric_shift = '0;
        s.prefix_shift = '0;
      end
    end else begin
      s.phase = PH_TLVSKIP;
    end
  endfunction

  function automatic void emit_prefix(input parse_st_t s, input logic [7:0] sub,
                                      inout res_item_t r0, inout res_item_t r1,
                                      inout logic [1:0] n);
    res_item_t   r;
    logic [5:0]  len;
    logic [31:0] mask;
    len = s.control_hold[5:0];
    if (len > PFX_LEN_MAX) len = PFX_LEN_MAX;
    mask = (len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - len));
    r = mk(KIND_PREFIX, ERR_NONE);
    r.metric = s.metric_shift;
    r.down_bit = s.control_hold[7];
    r.prefix_value = s.prefix_shift & mask;
    r.prefix_length = len;
    r.host_bits_set = ((s.prefix_shift & ~mask) != 32'd0);
    r.subtlv_length = sub;
    put(r0, r1, n, r);
  endfunction

  function automatic void after_prefix(inout parse_st_t s, input logic [LW-1:0] al,
                                       inout res_item_t r0, inout res_item_t r1,
                                       inout logic [1:0] n);
    if (s.control_hold[6]) begin
      if (s.tlv_left == 8'd0) fail(s, r0, r1, n, ERR_SUBLEN_MISS);
      else s.phase = PH_PSUBLEN;
    end else begin
      emit_prefix(s, 8'd0, r0, r1, n);
      advance(s, al, r0, r1, n);
    end
  endfunction

  function automatic void start_skip(inout parse_st_t s, input logic [LW-1:0] al,
                                     input logic [7:0] b, inout res_item_t r0,
                                     inout res_item_t r1, inout logic [1:0] n);
    if (b != 8'd0) begin
      s.skip_left = b;
      s.phase = PH_SUBSKIP;
    end else begin
      advance(s, al, r0, r1, n);
    end
  endfunction

  always_comb begin
    parse_st_t     s;
    logic [LW-1:0] al;
    logic [1:0]    n;
    res_item_t     r0, r1, nr;
    logic [7:0]    b;
    s = st;
    al = area_left;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    nr = '0;
    b = item.data_byte;
    if (item.area_start) begin
      al = LW'(item.area_length);
      s.tlv_code = '0;
      s.tlv_left = '0;
      s.skip_left = '0;
      advance(s, al, r0, r1, n);
    end
    if (s.phase != PH_IDLE) begin
      if (al != '0) al = al - LW'(1);
      if (s.phase != PH_TYPE && s.phase != PH_LEN && s.tlv_left != 8'd0)
        s.tlv_left = s.tlv_left - 8'd1;
      unique case (s.phase)
        PH_TYPE: begin
          s.tlv_code = b;
          s.phase = PH_LEN;
        end
        PH_LEN: begin
          s.tlv_left = b;
          if (al < LW'(b)) fail(s, r0, r1, n, ERR_TLV_OVERRUN);
          else advance(s, al, r0, r1, n);
        end
        PH_NBR: begin
          if (s.field_count < 4'd7) begin
            s.id_shift = {s.id_shift[47:0], b};
            s.field_count = s.field_count + 4'd1;
          end else if (s.field_count < 4'd10) begin
            s.metric_shift = {8'd0, s.metric_shift[15:0], b};
            s.field_count = s.field_count + 4'd1;
          end else if (s.tlv_left < b) begin
            fail(s, r0, r1, n, ERR_NBR_SUB);
          end else begin
            nr = mk(KIND_NBR, ERR_NONE);
            nr.neighbor_id = s.id_shift;
            nr.metric = s.metric_shift;
            nr.subtlv_length = b;
            put(r0, r1, n, nr);
            start_skip(s, al, b, r0, r1, n);
          end
        end
        PH_PMET: begin
          s.metric_shift = {s.metric_shift[23:0], b};
          s.field_count = s.field_count + 4'd1;
          if (s.field_count >= 4'd4) s.phase = PH_PCTL;
        end
        PH_PCTL: begin
          s.control_hold = b;
          if (b[5:0] > PFX_LEN_MAX) fail(s, r0, r1, n, ERR_LEN_OVER);
          else if (s.tlv_left < {4'd0, pfx_bytes(b)}) fail(s, r0, r1, n, ERR_PFX_BYTES);
          else if (pfx_bytes(b) == 4'd0) after_prefix(s, al, r0, r1, n);
          else begin
            s.field_count = '0;
            s.phase = PH_PBYTES;
          end
        end
        PH_PBYTES: begin
          if (s.field_count < 4'd4) begin
            unique case (s.field_count[1:0])
              2'd0: s.prefix_shift[31:24] = s.prefix_shift[31:24] | b;
              2'd1: s.prefix_shift[23:16] = s.prefix_shift[23:16] | b;
              2'd2: s.prefix_shift[15:8] = s.prefix_shift[15:8] | b;
              default: s.prefix_shift[7:0] = s.prefix_shift[7:0] | b;
            endcase
          end
          s.field_count = s.field_count + 4'd1;
          if (s.field_count >= pfx_bytes(s.control_hold)) after_prefix(s, al, r0, r1, n);
        end
        PH_PSUBLEN: begin
          if (s.tlv_left < b) fail(s, r0, r1, n, ERR_SUB_OVERRUN);
          else begin
            emit_prefix(s, b, r0, r1, n);
            start_skip(s, al, b, r0, r1, n);
          end
        end
        PH_SUBSKIP: begin
          if (s.skip_left != 8'd0) s.skip_left = s.skip_left - 8'd1;
          if (s.skip_left == 8'd0) advance(s, al, r0, r1, n);
        end
        PH_TLVSKIP: advance(s, al, r0, r1, n);
        default: s.phase = PH_IDLE;
      endcase
    end
    r0.last_result = (n == 2'd1);
    r1.last_result = 1'b1;
    st_next = s;
    area_left_next = al;
    res_cnt = n;
    res0 = r0;
    res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, default: '0};
      area_left <= '0;
    end else if (accept) begin
      st <= st_next;
      area_left <= area_left_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/reach_tlv_stream_parser_top.sv -----
// top level: tlv area byte parser with result queue
//
// channel  direction  handshake                    payload
// byte     in         byte_valid / byte_ready      rtsp_pkg::in_item_t
// rec      out        rec_valid / rec_ready        rtsp_pkg::res_item_t
//
// each byte is decoded in the cycle it is accepted; its zero, one or two
// results enter a four-entry queue and leave one per cycle while rec_ready
// is high; a byte is taken whenever the queue has room for two more
// results, so bytes flow at one per cycle while most bytes give at most one
// result and rec_ready stays high; reset is synchronous and clears parse
// state and the queue
`default_nettype none
module reach_tlv_stream_parser_top #(
  parameter int AREA_LENGTH_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire rtsp_pkg::in_item_t  byte_item,
  output logic                     rec_valid,
  input  wire logic                rec_ready,
  output rtsp_pkg::res_item_t      rec_item
);
  import rtsp_pkg::*;

  // the area counter never needs more than the 16 bits of the length field
  localparam int LW = (AREA_LENGTH_BITS < 16) ? AREA_LENGTH_BITS : 16;

  logic       accept;
  logic [1:0] res_cnt;
  res_item_t  res0, res1;

  // result queue
  res_item_t  q [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] push_n;

  assign byte_ready = (count <= 3'd2);
  assign accept     = byte_valid && byte_ready;
  assign rec_valid  = (count != 3'd0);
  assign rec_item   = q[rd_ptr];
  assign pop        = rec_valid && rec_ready;
  assign push_n     = accept ? {1'b0, res_cnt} : 3'd0;

  rtsp_parse #(.LW(LW)) u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (byte_item),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // payload entries hold no reset
  always_ff @(posedge clk) begin
    if (push_n != 3'd0) q[wr_ptr] <= res0;
    if (push_n == 3'd2) q[wr_ptr + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + push_n - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- test/reach_tlv_stream_parser_top_tb.sv -----
// self-checking testbench for the reachability tlv stream parser top level
`default_nettype none
module reach_tlv_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtsp_pkg::*;

  // local phase codes for the predictor
  typedef enum int {
    S_IDLE, S_TYPE, S_LEN, S_NBR, S_PMET, S_PCTL, S_PBYTES, S_PSUBLEN, S_SUBSKIP, S_TLVSKIP
  } pstate_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  in_item_t byte_item = '0;
  logic rec_valid;
  logic rec_ready = 1'b0;
  res_item_t rec_item;

  reach_tlv_stream_parser_top u_top (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_ready(byte_ready), .byte_item(byte_item),
    .rec_valid(rec_valid), .rec_ready(rec_ready), .rec_item(rec_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  pstate_e     ph = S_IDLE;
  logic [15:0] a_left = '0;
  logic [7:0]  t_code = '0;
  logic [7:0]  t_left = '0;
  logic [3:0]  f_cnt = '0;
  logic [55:0] id_sh = '0;
  logic [31:0] met_sh = '0;
  logic [7:0]  ctl = '0;
  logic [31:0] pfx_sh = '0;
  logic [7:0]  skip = '0;

  in_item_t  byte_q[$];     // items queued for the driver
  res_item_t expected_recs[$];
  res_item_t step_recs[$];
  int        err_count = 0;
  bit        hold_off = 1'b0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  function automatic void add_rec(input logic [1:0] k, input logic [3:0] e,
                                  input logic [55:0] id, input logic [31:0] m,
                                  input logic d, input logic [31:0] pv,
                                  input logic [5:0] pl, input logic hb,
                                  input logic [7:0] sub);
    res_item_t r;
    r = '0;
    r.record_kind = k; r.error_code = e; r.neighbor_id = id; r.metric = m;
    r.down_bit = d; r.prefix_value = pv; r.prefix_length = pl;
    r.host_bits_set = hb; r.subtlv_length = sub;
    if (step_recs.size() < 2) step_recs.push_back(r);
  endfunction

  function automatic void area_fail(input logic [3:0] code);
    add_rec(KIND_ERROR, code, '0, '0, 1'b0, '0, '0, 1'b0, '0);
    ph = S_IDLE;
  endfunction

  function automatic int pfx_nbytes();
    return (int'(ctl[5:0]) + 7) >> 3;
  endfunction

  function automatic void emit_prefix(input logic [7:0] sub);
    int len;
    logic [31:0] mask;
    len = ctl[5:0];
    if (len > 32) len = 32;
    mask = (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
    add_rec(KIND_PREFIX, ERR_NONE, '0, met_sh, ctl[7], pfx_sh & mask, len[5:0],
            (pfx_sh & ~mask) != 0, sub);
  endfunction

  // what comes after a header, an item or a skipped run
  function automatic void next_step();
    if (t_left == 0) begin
      if (a_left == 0) begin
        add_rec(KIND_DONE, ERR_NONE, '0, '0, 1'b0, '0, '0, 1'b0, '0);
        ph = S_IDLE;
      end else if (a_left < 2) begin
        area_fail(ERR_HDR_SHORT);
      end else begin
        ph = S_TYPE;
      end
    end else if (t_code == TLV_EXT_IS_REACH) begin
      if (t_left < NBR_ITEM_BYTES) area_fail(ERR_NBR_SHORT);
      else begin
        ph = S_NBR; f_cnt = 0; id_sh = 0; met_sh = 0;
      end
    end else if (t_code == TLV_EXT_IP_REACH) begin
      if (t_left < PFX_ITEM_MIN) area_fail(ERR_PFX_SHORT);
      else begin
        ph = S_PMET; f_cnt = 0; met_sh = 0; pfx_sh = 0;
      end
    end else begin
      ph = S_TLVSKIP;
    end
  endfunction

  function automatic void after_prefix();
    if (ctl[6]) begin
      if (t_left < 1) area_fail(ERR_SUBLEN_MISS);
      else ph = S_PSUBLEN;
    end else begin
      emit_prefix(8'd0);
      next_step();
    end
  endfunction

  function automatic void begin_skip(input logic [7:0] n);
    if (n != 0) begin
      skip = n; ph = S_SUBSKIP;
    end else begin
      next_step();
    end
  endfunction

  // advance the predictor by one byte and queue what it yields
  function automatic void predict_byte(input in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    step_recs.delete();
    if (it.area_start) begin
      a_left = it.area_length; t_code = 0; t_left = 0; skip = 0;
      next_step();
    end
    if (ph != S_IDLE) begin
      if (a_left != 0) a_left--;
      if (ph != S_TYPE && ph != S_LEN && t_left != 0) t_left--;
      case (ph)
        S_TYPE: begin
          t_code = b; ph = S_LEN;
        end
        S_LEN: begin
          t_left = b;
          if (a_left < b) area_fail(ERR_TLV_OVERRUN);
          else next_step();
        end
        S_NBR: begin
          if (f_cnt < 7) begin
            id_sh = {id_sh[47:0], b}; f_cnt++;
          end else if (f_cnt < 10) begin
            met_sh = {8'd0, met_sh[15:0], b}; f_cnt++;
          end else if (t_left < b) begin
            area_fail(ERR_NBR_SUB);
          end else begin
            add_rec(KIND_NBR, ERR_NONE, id_sh, met_sh, 1'b0, '0, '0, 1'b0, b);
            begin_skip(b);
          end
        end
        S_PMET: begin
          met_sh = {met_sh[23:0], b}; f_cnt++;
          if (f_cnt >= 4) ph = S_PCTL;
        end
        S_PCTL: begin
          ctl = b;
          if (b[5:0] > PFX_LEN_MAX) area_fail(ERR_LEN_OVER);
          else if (int'(t_left) < pfx_nbytes()) area_fail(ERR_PFX_BYTES);
          else if (pfx_nbytes() == 0) after_prefix();
          else begin
            f_cnt = 0; ph = S_PBYTES;
          end
        end
        S_PBYTES: begin
          if (f_cnt < 4) pfx_sh |= 32'(b) << (24 - 8 * f_cnt);
          f_cnt++;
          if (int'(f_cnt) >= pfx_nbytes()) after_prefix();
        end
        S_PSUBLEN: begin
          if (t_left < b) area_fail(ERR_SUB_OVERRUN);
          else begin
            emit_prefix(b);
            begin_skip(b);
          end
        end
        S_SUBSKIP: begin
          if (skip != 0) skip--;
          if (skip == 0) next_step();
        end
        S_TLVSKIP: next_step();
        default: ph = S_IDLE;
      endcase
    end
    foreach (step_recs[i]) begin
      res_item_t r;
      r = step_recs[i];
      r.last_result = (i == step_recs.size() - 1);
      expected_recs.push_back(r);
    end
  endfunction

  // stimulus builders
  function automatic void put_byte(input logic [7:0] b, input bit st = 0,
                                   input logic [15:0] len = 0);
    in_item_t it;
    it.data_byte = b; it.area_start = st; it.area_length = len;
    if (!st) it.area_length = 16'($urandom);  // ignored without start
    byte_q.push_back(it);
  endfunction

  // a random tlv (type, length and body), mostly well formed
  function automatic void build_tlv(ref logic [7:0] buf_q[$]);
    int kind, n, k, plen, nb;
    logic [7:0] body[$];
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < 10; j++) body.push_back(8'($urandom));
        k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        body.push_back(8'(k));
        for (int j = 0; j < k; j++) body.push_back(8'($urandom));
      end
      buf_q.push_back(TLV_EXT_IS_REACH);
    end else if (kind < 8) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < 4; j++) body.push_back(8'($urandom));
        plen = $urandom_range(0, 32);
        k = $urandom_range(0, 1);
        body.push_back({1'($urandom), 1'(k), 6'(plen)});
        nb = (plen + 7) / 8;
        for (int j = 0; j < nb; j++) body.push_back(8'($urandom));
        if (k) begin
          nb = $urandom_range(0, 5);
          body.push_back(8'(nb));
          for (int j = 0; j < nb; j++) body.push_back(8'($urandom));
        end
      end
      buf_q.push_back(TLV_EXT_IP_REACH);
    end else begin
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      buf_q.push_back(8'($urandom_range(0, 255)));
    end
    // occasionally corrupt the body
    if ($urandom_range(0, 9) == 0 && body.size() > 0)
      body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    buf_q.push_back(8'(body.size()));
    foreach (body[i]) buf_q.push_back(body[i]);
  endfunction

  function automatic void build_area();
    logic [7:0] ab[$];
    int t, len;
    t = $urandom_range(1, 3);
    for (int i = 0; i < t; i++) build_tlv(ab);
    len = ab.size();
    case ($urandom_range(0, 11))
      0: len = len + int'($urandom_range(0, 6)) - 3;
      1: ab = ab[0:$urandom_range(0, ab.size() - 1)];  // cut short, next start abandons
      2: len = 16'($urandom);
      default: ;
    endcase
    if (len < 0) len = 0;
    if (ab.size() == 0) ab.push_back(8'($urandom));
    put_byte(ab[0], 1, 16'(len));
    for (int i = 1; i < ab.size(); i++) put_byte(ab[i]);
    if ($urandom_range(0, 5) == 0) put_byte(8'($urandom));  // noise after the area
  endfunction

  // directed areas covering each error and the corner lengths, split over two tasks
  task automatic directed();
    put_byte(8'h00, 1, 16'd0);              // empty area gives done at once
    put_byte(8'hff, 1, 16'd1);              // one-byte area is short
    put_byte(8'h55);                        // ignored byte outside an area
    put_byte(8'd22, 1, 16'd3); put_byte(8'd5);          // tlv overruns area
    put_byte(8'd22, 1, 16'd4); put_byte(8'd2);          // neighbor short
    put_byte(8'd22, 1, 16'd13); put_byte(8'd11);
    for (int i = 0; i < 10; i++) put_byte(8'hff);
    put_byte(8'd1);                                     // neighbor sub-tlv overrun
    put_byte(8'd135, 1, 16'd4); put_byte(8'd2);         // prefix item short
    put_byte(8'd135, 1, 16'd7); put_byte(8'd5);
    for (int i = 0; i < 4; i++) put_byte(8'hff);
    put_byte(8'h3f);                                    // length over 32
  endtask

  task automatic directed2();
    put_byte(8'd135, 1, 16'd7); put_byte(8'd5);
    for (int i = 0; i < 4; i++) put_byte(8'h00);
    put_byte(8'h08);                                    // prefix bytes short
    put_byte(8'd135, 1, 16'd7); put_byte(8'd5);
    for (int i = 0; i < 4; i++) put_byte(8'h00);
    put_byte(8'h40);                                    // sub-tlv length missing
    put_byte(8'd135, 1, 16'd13); put_byte(8'd11);
    for (int i = 0; i < 4; i++) put_byte(8'hff);
    put_byte(8'hdf); for (int i = 0; i < 4; i++) put_byte(8'hff);
    put_byte(8'd2);                                     // sub-tlv overrun
    put_byte(8'd135, 1, 16'd11); put_byte(8'd9);
    for (int i = 0; i < 4; i++) put_byte(8'h12);
    put_byte(8'h95); for (int i = 0; i < 3; i++) put_byte(8'hff); // host bits, down bit
  endtask

  initial begin
    directed();
    directed2();
    while (byte_q.size() < 1700) build_area();
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) predict_byte(byte_item);
      if (!byte_valid || byte_ready) begin
        if (gap_left > 0 || hold_off || byte_q.size() == 0) begin
          byte_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          byte_item <= byte_q.pop_front();
          byte_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern and result checking
  int rx_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      rec_ready <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) begin
        if (expected_recs.size() == 0) begin
          report($sformatf("unexpected record kind %0d", rec_item.record_kind));
        end else begin
          res_item_t e;
          e = expected_recs.pop_front();
          if (rec_item.record_kind !== e.record_kind) report("record_kind");
          if (rec_item.error_code !== e.error_code) report("error_code");
          if (rec_item.neighbor_id !== e.neighbor_id) report("neighbor_id");
          if (rec_item.metric !== e.metric) report("metric");
          if (rec_item.down_bit !== e.down_bit) report("down_bit");
          if (rec_item.prefix_value !== e.prefix_value) report("prefix_value");
          if (rec_item.prefix_length !== e.prefix_length) report("prefix_length");
          if (rec_item.host_bits_set !== e.host_bits_set) report("host_bits_set");
          if (rec_item.subtlv_length !== e.subtlv_length) report("subtlv_length");
          if (rec_item.last_result !== e.last_result) report("last_result");
        end
      end
      rx_phase <= (rx_phase + 1) % 600;
      // stretches of full speed, periodic stalls, and random stalls
      if (rx_phase < 200) rec_ready <= 1'b1;
      else if (rx_phase < 400) rec_ready <= (rx_phase % 5) != 0;
      else rec_ready <= $urandom_range(0, 2) != 0;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // let some traffic build, then drain fully once before continuing
    wait (byte_q.size() < 900);
    @(posedge clk);
    hold_off <= 1'b1;
    @(posedge clk);
    wait (!byte_valid && expected_recs.size() == 0);
    repeat (5) @(posedge clk);
    hold_off <= 1'b0;
    wait (byte_q.size() == 0 && !byte_valid);
    wait (expected_recs.size() == 0);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("reach_tlv_stream_parser_top_tb: done, clean");
    end else begin
      $display("reach_tlv_stream_parser_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("reach_tlv_stream_parser_top_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
